FILE: rtl/core/i2cmbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmbs_pkg
// Shared types and constants of the byte-level i2c master sequencer.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

  // width of the phase length counter compare
  localparam int PHASE_COUNT_BITS = 16;
  localparam int TICK_W           = 16;

  localparam logic [TICK_W-1:0] PHASE_MASK =
    (PHASE_COUNT_BITS >= TICK_W) ? {TICK_W{1'b1}} : TICK_W'((1 << PHASE_COUNT_BITS) - 1);

  localparam logic [TICK_W-1:0] TPP_RESET = 16'd5;

  // command and operation codes
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // phase counts per operation
  localparam logic [4:0] LEN_START = 5'd3;
  localparam logic [4:0] LEN_STOP  = 5'd3;
  localparam logic [4:0] LEN_WRITE = 5'd27;
  localparam logic [4:0] LEN_READ  = 5'd19;

  localparam logic [2:0] MSB_INDEX = 3'd7;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic       read_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] read_data;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [2:0]        active_op;
    logic [4:0]        phase_index;
    logic [TICK_W-1:0] tick_count;
    logic [7:0]        shift_byte;
    logic              ack_choice;
    logic              ack_result;
    logic              scl_level;
    logic              sda_level;
  } seq_state_t;

  // idle sequencer with both lines released
  localparam seq_state_t SEQ_RESET = '{
    active_op:   OP_IDLE,
    phase_index: 5'd0,
    tick_count:  {TICK_W{1'b0}},
    shift_byte:  8'd0,
    ack_choice:  1'b0,
    ack_result:  1'b0,
    scl_level:   1'b1,
    sda_level:   1'b1
  };

endpackage
`default_nettype wire

FILE: rtl/core/i2cmbs_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmbs channels
// Valid/ready channel interfaces for command, result and configuration beats.
// ----------------------------------------------------------------------------
interface i2cmbs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] write_data;
  logic       read_ack;
  logic       sda_in;

  modport source (output valid, command, write_data, read_ack, sda_in, input ready);
  modport sink   (input valid, command, write_data, read_ack, sda_in, output ready);
endinterface

interface i2cmbs_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic       ack_seen;
  logic [7:0] read_data;
  logic       rejected;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, ack_seen, read_data,
                  rejected, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, ack_seen, read_data,
                  rejected, output ready);
endinterface

interface i2cmbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/i2cmbs_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmbs_step
// Sequencer state and the per-tick next-state and result logic.
// ----------------------------------------------------------------------------
module i2cmbs_step (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire i2cmbs_pkg::in_item_t           item_i,
  input  wire logic [i2cmbs_pkg::TICK_W-1:0]  tpp_i,
  output i2cmbs_pkg::out_item_t               res_o
);

  i2cmbs_pkg::seq_state_t st_q, st_d;

  // number of phases of an operation
  function automatic logic [4:0] op_length(input logic [2:0] op);
    logic [4:0] n;
    case (op)
      i2cmbs_pkg::OP_START: n = i2cmbs_pkg::LEN_START;
      i2cmbs_pkg::OP_STOP:  n = i2cmbs_pkg::LEN_STOP;
      i2cmbs_pkg::OP_WRITE: n = i2cmbs_pkg::LEN_WRITE;
      i2cmbs_pkg::OP_READ:  n = i2cmbs_pkg::LEN_READ;
      default:              n = 5'd0;
    endcase
    return n;
  endfunction

  // line levels set on phase entry
  function automatic i2cmbs_pkg::seq_state_t enter_phase(input i2cmbs_pkg::seq_state_t s,
                                                         input logic [4:0] p);
    i2cmbs_pkg::seq_state_t r;
    logic [2:0] bit_idx;
    logic [4:0] sub;
    r = s;
    // bit number and sub-phase of a data phase, p split by three
    bit_idx = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (p >= 5'(3 * i)) bit_idx = 3'(i);
    end
    sub = p - 5'(3 * bit_idx);
    case (s.active_op)
      i2cmbs_pkg::OP_START: begin
        if (p == 5'd0) begin
          r.sda_level = 1'b1;
          r.scl_level = 1'b1;
        end else if (p == 5'd1) begin
          r.sda_level = 1'b0;
        end else begin
          r.scl_level = 1'b0;
        end
      end
      i2cmbs_pkg::OP_STOP: begin
        if (p == 5'd0)      r.sda_level = 1'b0;
        else if (p == 5'd1) r.scl_level = 1'b1;
        else                r.sda_level = 1'b1;
      end
      i2cmbs_pkg::OP_WRITE: begin
        if (p < 5'd24) begin
          if (sub == 5'd0)      r.sda_level = s.shift_byte[i2cmbs_pkg::MSB_INDEX - bit_idx];
          else if (sub == 5'd1) r.scl_level = 1'b1;
          else                  r.scl_level = 1'b0;
        end else if (p == 5'd24) begin
          r.sda_level = 1'b1;
        end else if (p == 5'd25) begin
          r.scl_level = 1'b1;
        end else begin
          r.scl_level = 1'b0;
        end
      end
      i2cmbs_pkg::OP_READ: begin
        if (p < 5'd16) begin
          if (p == 5'd0) r.sda_level = 1'b1;
          r.scl_level = ~p[0];
        end else if (p == 5'd16) begin
          r.sda_level = ~s.ack_choice;
        end else if (p == 5'd17) begin
          r.scl_level = 1'b1;
        end else begin
          r.scl_level = 1'b0;
        end
      end
      default: r = s;
    endcase
    return r;
  endfunction

  logic [i2cmbs_pkg::TICK_W-1:0] plen;
  logic [i2cmbs_pkg::TICK_W-1:0] tc_inc;
  logic [4:0]                    pi_inc;
  i2cmbs_pkg::seq_state_t        s0;
  i2cmbs_pkg::out_item_t         res;

  // effective phase length, zero acts as one
  always_comb begin
    plen = tpp_i & i2cmbs_pkg::PHASE_MASK;
    if (plen == '0) plen = {{(i2cmbs_pkg::TICK_W-1){1'b0}}, 1'b1};
  end

  // one tick of the sequencer
  always_comb begin
    s0  = st_q;
    res = '0;
    if (st_q.active_op != i2cmbs_pkg::OP_IDLE) begin
      res.rejected = (item_i.command != i2cmbs_pkg::OP_IDLE);
    end else if (item_i.command >= i2cmbs_pkg::OP_START &&
                 item_i.command <= i2cmbs_pkg::OP_READ) begin
      s0.active_op   = item_i.command;
      s0.phase_index = 5'd0;
      s0.tick_count  = '0;
      if (item_i.command == i2cmbs_pkg::OP_WRITE) begin
        s0.shift_byte = item_i.write_data;
        s0.ack_result = 1'b0;
      end
      if (item_i.command == i2cmbs_pkg::OP_READ) begin
        s0.shift_byte = 8'd0;
        s0.ack_choice = item_i.read_ack;
      end
      s0 = enter_phase(s0, 5'd0);
    end

    res.scl_out = s0.scl_level;
    res.sda_out = s0.sda_level;

    st_d   = s0;
    tc_inc = s0.tick_count + 1'b1;
    pi_inc = s0.phase_index + 1'b1;
    if (s0.active_op != i2cmbs_pkg::OP_IDLE) begin
      res.busy_res  = 1'b1;
      st_d.tick_count = tc_inc;
      if (tc_inc >= plen || tc_inc == '0) begin
        // end-of-phase sample
        if (s0.active_op == i2cmbs_pkg::OP_WRITE && s0.phase_index == 5'd25) begin
          st_d.ack_result = ~item_i.sda_in;
        end else if (s0.active_op == i2cmbs_pkg::OP_READ && s0.phase_index < 5'd16 &&
                     !s0.phase_index[0]) begin
          st_d.shift_byte = {s0.shift_byte[6:0], item_i.sda_in};
        end
        st_d.tick_count  = '0;
        st_d.phase_index = pi_inc;
        if (pi_inc >= op_length(s0.active_op)) begin
          res.done_res = 1'b1;
          if (s0.active_op == i2cmbs_pkg::OP_WRITE) res.ack_seen = st_d.ack_result;
          if (s0.active_op == i2cmbs_pkg::OP_READ)  res.read_data = st_d.shift_byte;
          st_d.active_op   = i2cmbs_pkg::OP_IDLE;
          st_d.phase_index = 5'd0;
        end else begin
          st_d = enter_phase(st_d, pi_inc);
        end
      end
    end
  end

  assign res_o = res;

  // sequencer state advances once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= i2cmbs_pkg::SEQ_RESET;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/i2c_master_byte_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer
// Byte-level i2c master: start, stop, write byte and read byte sequences.
// ----------------------------------------------------------------------------
// Every input beat is one tick of time and returns exactly one result beat.
// The block takes one beat per clock cycle; a result passes through the input
// register, then the result register, and the input side stalls only while a
// result beat is held by the downstream sink. The rate is set by the one-tick
// state update of the sequencer. The phase length register (reset 5) is written
// over the config channel; the user must write it only while no beat is in
// flight, as the block itself does not enforce this.
module i2c_master_byte_sequencer (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  i2cmbs_in_if.sink    in_ch,
  i2cmbs_out_if.source out_ch,
  i2cmbs_cfg_if.sink   cfg_ch
);

  logic                          in_vld_q;
  i2cmbs_pkg::in_item_t          in_q;
  logic                          out_vld_q;
  i2cmbs_pkg::out_item_t         out_q;
  logic [i2cmbs_pkg::TICK_W-1:0] tpp_q;
  logic                          advance;
  i2cmbs_pkg::out_item_t         res;

  // stage handshake
  assign advance     = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready = !in_vld_q || advance;
  assign cfg_ch.ready = 1'b1;

  // phase length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpp_q <= i2cmbs_pkg::TPP_RESET;
    end else if (cfg_ch.valid) begin
      tpp_q <= cfg_ch.data;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q.command    <= in_ch.command;
      in_q.write_data <= in_ch.write_data;
      in_q.read_ack   <= in_ch.read_ack;
      in_q.sda_in     <= in_ch.sda_in;
    end
  end

  i2cmbs_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .tpp_i  (tpp_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= res;
  end

  assign out_ch.valid     = out_vld_q;
  assign out_ch.scl_out   = out_q.scl_out;
  assign out_ch.sda_out   = out_q.sda_out;
  assign out_ch.busy_res  = out_q.busy_res;
  assign out_ch.done_res  = out_q.done_res;
  assign out_ch.ack_seen  = out_q.ack_seen;
  assign out_ch.read_data = out_q.read_data;
  assign out_ch.rejected  = out_q.rejected;

endmodule
`default_nettype wire
